// ===== src/sobel_edge_magnitude_assert.svh =====
// ----------------------------------------------------------------------------
// sobel edge magnitude assertion macros
// concurrent assertion wrappers, compiled out when ASSERT_OFF is defined
// ----------------------------------------------------------------------------
`ifndef SOBEL_EDGE_MAGNITUDE_ASSERT_SVH
`define SOBEL_EDGE_MAGNITUDE_ASSERT_SVH
`ifndef ASSERT_OFF
`define SEM_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define SEM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define SEM_ASSERT(lbl, clk, rst_n, prop, msg)
`define SEM_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// ===== src/sem_pkg.sv =====
// ----------------------------------------------------------------------------
// sem_pkg
// shared widths, register codes and beat types of the sobel edge magnitude block
// ----------------------------------------------------------------------------
package sem_pkg;

    localparam int PIX_W          = 8;
    localparam int CFG_W          = 11;
    localparam int CFG_IDX_W      = 1;
    localparam int POS_W          = 10;
    localparam int GRAD_W         = 11;
    localparam int SQ_W           = 20;
    localparam int SUM_W          = 21;
    localparam int RAD_W          = 16;
    localparam int ROOT_W         = 8;
    localparam int REM_W          = 9;
    localparam int SQ_STEPS       = 8;
    localparam int MIN_DIM        = 3;
    localparam int DIM_RESET      = 1024;
    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 1'b1;

    localparam logic [ROOT_W-1:0] MAG_MAX = 8'd255;

    typedef struct packed {
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
        logic             last;
    } t_tag;

    typedef struct packed {
        logic signed [GRAD_W-1:0] gx;
        logic signed [GRAD_W-1:0] gy;
        t_tag                     tag;
    } t_grad;

endpackage

// ===== src/sem_ram.sv =====
// ----------------------------------------------------------------------------
// sem_ram
// generic single write port ram with one registered read port
// ----------------------------------------------------------------------------
module sem_ram #(
    parameter int WIDTH = 2 * sem_pkg::PIX_W,
    parameter int DEPTH = sem_pkg::DEF_MAX_WIDTH
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/sem_window.sv =====
// ----------------------------------------------------------------------------
// sem_window
// raster position counters, line store memory, 3x3 window and sobel gradients
// ----------------------------------------------------------------------------
`include "sobel_edge_magnitude_assert.svh"

module sem_window #(
    parameter int MAX_WIDTH  = sem_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = sem_pkg::DEF_MAX_HEIGHT
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_en,
    input  logic                           i_pix_valid,
    input  logic [sem_pkg::PIX_W-1:0]      i_pixel,
    input  logic                           i_cfg_we,
    input  logic [sem_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [sem_pkg::CFG_W-1:0]      i_cfg_data,
    output logic                           o_valid,
    output sem_pkg::t_grad                 o_grad
);

    import sem_pkg::*;

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int ROW_W = $clog2(MAX_HEIGHT);
    localparam logic [COL_W-1:0] COL_LAST_MAX = COL_W'(MAX_WIDTH - 1);
    localparam logic [ROW_W-1:0] ROW_LAST_MAX = ROW_W'(MAX_HEIGHT - 1);
    localparam logic [COL_W-1:0] COL_LAST_RST =
        COL_W'(((MAX_WIDTH < DIM_RESET) ? MAX_WIDTH : DIM_RESET) - 1);
    localparam logic [ROW_W-1:0] ROW_LAST_RST =
        ROW_W'(((MAX_HEIGHT < DIM_RESET) ? MAX_HEIGHT : DIM_RESET) - 1);

    logic [COL_W-1:0] r_col, n_col;
    logic [ROW_W-1:0] r_row, n_row;
    logic [COL_W-1:0] r_w_last, n_w_last;
    logic [ROW_W-1:0] r_h_last, n_h_last;
    logic [PIX_W-1:0] r_win [0:5];
    logic             r_valid;
    t_grad            r_grad;

    logic                 pix_acc;
    logic                 win_ok;
    logic [2*PIX_W-1:0]   rd_data;
    logic [PIX_W-1:0]     top, mid;
    logic [PIX_W+1:0]     gx_pos, gx_neg, gy_pos, gy_neg;
    logic [COL_W-1:0]     cfg_w_last;
    logic [ROW_W-1:0]     cfg_h_last;
    t_grad                n_grad;

    assign pix_acc = i_pix_valid & i_en;

    // clamp register writes into the supported range
    always_comb begin
        if (i_cfg_data < CFG_W'(MIN_DIM)) begin
            cfg_w_last = COL_W'(MIN_DIM - 1);
        end else if (32'(i_cfg_data) > MAX_WIDTH) begin
            cfg_w_last = COL_LAST_MAX;
        end else begin
            cfg_w_last = COL_W'(i_cfg_data - CFG_W'(1));
        end
        if (i_cfg_data < CFG_W'(MIN_DIM)) begin
            cfg_h_last = ROW_W'(MIN_DIM - 1);
        end else if (32'(i_cfg_data) > MAX_HEIGHT) begin
            cfg_h_last = ROW_LAST_MAX;
        end else begin
            cfg_h_last = ROW_W'(i_cfg_data - CFG_W'(1));
        end
    end

    always_comb begin
        n_col    = r_col;
        n_row    = r_row;
        n_w_last = r_w_last;
        n_h_last = r_h_last;
        if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_IMAGE_WIDTH:  n_w_last = cfg_w_last;
                CFG_IMAGE_HEIGHT: n_h_last = cfg_h_last;
                default:          n_w_last = r_w_last;
            endcase
            n_col = '0;
            n_row = '0;
        end else if (pix_acc) begin
            if (r_col == r_w_last) begin
                n_col = '0;
                n_row = (r_row == r_h_last) ? '0 : r_row + ROW_W'(1);
            end else begin
                n_col = r_col + COL_W'(1);
            end
        end
    end

    // entry holds {upper row, lower row}; read address runs one column ahead
    sem_ram #(
        .WIDTH (2 * PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (pix_acc),
        .i_waddr (r_col),
        .i_wdata ({mid, i_pixel}),
        .i_raddr (n_col),
        .o_rdata (rd_data)
    );

    assign top = rd_data[2*PIX_W-1:PIX_W];
    assign mid = rd_data[PIX_W-1:0];

    assign win_ok = (r_row >= ROW_W'(2)) && (r_col >= COL_W'(2));

    always_comb begin
        gx_pos = {2'b00, top} + {1'b0, mid, 1'b0} + {2'b00, i_pixel};
        gx_neg = {2'b00, r_win[0]} + {1'b0, r_win[1], 1'b0} + {2'b00, r_win[2]};
        gy_pos = {2'b00, r_win[2]} + {1'b0, r_win[5], 1'b0} + {2'b00, i_pixel};
        gy_neg = {2'b00, r_win[0]} + {1'b0, r_win[3], 1'b0} + {2'b00, top};
        n_grad.gx       = $signed({1'b0, gx_pos}) - $signed({1'b0, gx_neg});
        n_grad.gy       = $signed({1'b0, gy_pos}) - $signed({1'b0, gy_neg});
        n_grad.tag.row  = POS_W'(r_row - ROW_W'(1));
        n_grad.tag.col  = POS_W'(r_col - COL_W'(1));
        n_grad.tag.last = (r_row == r_h_last) && (r_col == r_w_last);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col    <= '0;
            r_row    <= '0;
            r_w_last <= COL_LAST_RST;
            r_h_last <= ROW_LAST_RST;
            r_valid  <= 1'b0;
        end else begin
            r_col    <= n_col;
            r_row    <= n_row;
            r_w_last <= n_w_last;
            r_h_last <= n_h_last;
            if (i_en) begin
                r_valid <= pix_acc & win_ok;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pix_acc) begin
            r_win[0] <= r_win[3];
            r_win[1] <= r_win[4];
            r_win[2] <= r_win[5];
            r_win[3] <= top;
            r_win[4] <= mid;
            r_win[5] <= i_pixel;
        end
        if (i_en) begin
            r_grad <= n_grad;
        end
    end

    assign o_valid = r_valid;
    assign o_grad  = r_grad;

    `SEM_ASSERT(a_col_bound, i_clk, i_rst_n, r_col <= r_w_last, "column past row end")
    `SEM_ASSERT(a_row_bound, i_clk, i_rst_n, r_row <= r_h_last, "row past frame end")
    `SEM_ASSERT(a_col_wrap, i_clk, i_rst_n, pix_acc && r_col == r_w_last |=> r_col == '0, "column did not wrap")
    `SEM_ASSERT(a_cfg_restart, i_clk, i_rst_n, i_cfg_we |=> r_col == '0 && r_row == '0, "frame not restarted")
    `SEM_ASSERT_ALWAYS(a_rst_pos, i_clk, !i_rst_n |=> r_col == '0 && r_row == '0 && !r_valid, "reset state")

endmodule

// ===== src/sem_mag.sv =====
// ----------------------------------------------------------------------------
// sem_mag
// squares, sum and bit-per-stage floor square root with saturation
// ----------------------------------------------------------------------------
module sem_mag (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_valid,
    input  sem_pkg::t_grad              i_grad,
    output logic                        o_valid,
    output logic [sem_pkg::ROOT_W-1:0]  o_edge_value,
    output sem_pkg::t_tag               o_tag
);

    import sem_pkg::*;

    logic signed [2*GRAD_W-1:0] prod_x, prod_y;
    logic [SUM_W-1:0]           sum;

    logic             r_v2;
    t_tag             r_tag2;
    logic [SQ_W-1:0]  r_sqx, r_sqy;

    logic              r_sv    [0:SQ_STEPS];
    t_tag              r_stag  [0:SQ_STEPS];
    logic              r_ssat  [0:SQ_STEPS];
    logic [RAD_W-1:0]  r_srad  [0:SQ_STEPS-1];
    logic [REM_W-1:0]  r_srem  [1:SQ_STEPS-1];
    logic [ROOT_W-1:0] r_sroot [1:SQ_STEPS];

    assign prod_x = i_grad.gx * i_grad.gx;
    assign prod_y = i_grad.gy * i_grad.gy;
    assign sum    = {1'b0, r_sqx} + {1'b0, r_sqy};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2     <= 1'b0;
            r_sv[0]  <= 1'b0;
        end else if (i_en) begin
            r_v2     <= i_valid;
            r_sv[0]  <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_tag2    <= i_grad.tag;
            r_sqx     <= prod_x[SQ_W-1:0];
            r_sqy     <= prod_y[SQ_W-1:0];
            r_stag[0] <= r_tag2;
            r_ssat[0] <= |sum[SUM_W-1:RAD_W];
            r_srad[0] <= sum[RAD_W-1:0];
        end
    end

    for (genvar k = 1; k <= SQ_STEPS; k++) begin : g_stage
        logic [REM_W-1:0]  prev_rem;
        logic [ROOT_W-1:0] prev_root;
        logic [REM_W+1:0]  rem_sh;
        logic [REM_W+1:0]  trial;
        logic              ge;

        if (k == 1) begin : g_first
            assign prev_rem  = '0;
            assign prev_root = '0;
        end else begin : g_next
            assign prev_rem  = r_srem[k-1];
            assign prev_root = r_sroot[k-1];
        end

        assign rem_sh = {prev_rem, r_srad[k-1][RAD_W-1 -: 2]};
        assign trial  = {1'b0, prev_root, 2'b01};
        assign ge     = rem_sh >= trial;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sv[k] <= 1'b0;
            end else if (i_en) begin
                r_sv[k] <= r_sv[k-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_stag[k]  <= r_stag[k-1];
                r_ssat[k]  <= r_ssat[k-1];
                r_sroot[k] <= {prev_root[ROOT_W-2:0], ge};
            end
        end

        if (k < SQ_STEPS) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_srad[k] <= {r_srad[k-1][RAD_W-3:0], 2'b00};
                    r_srem[k] <= ge ? REM_W'(rem_sh - trial) : REM_W'(rem_sh);
                end
            end
        end
    end

    assign o_valid      = r_sv[SQ_STEPS];
    assign o_tag        = r_stag[SQ_STEPS];
    assign o_edge_value = r_ssat[SQ_STEPS] ? MAG_MAX : r_sroot[SQ_STEPS];

endmodule

// ===== src/sobel_edge_magnitude.sv =====
// ----------------------------------------------------------------------------
// sobel_edge_magnitude
// 3x3 sobel gradient magnitude over a raster stream of 8-bit grey pixels
// ----------------------------------------------------------------------------
// Pixels enter in raster order on the pixel channel (i_pix_valid, o_pix_stall,
// i_pixel). For every pixel that completes a window with an interior centre,
// one beat leaves on the edge channel (o_edge_valid, i_edge_stall) carrying
// the saturated floor magnitude, the centre row and column and a flag on the
// last interior result of the frame. Border pixels produce no beat.
// Throughput is one pixel per cycle while o_pix_stall is low. The line stores
// sit in one ram read one pixel ahead, so one read gives both upper rows of
// each pixel; a result passes the window stage, squares, sum, and one root
// bit per stage over eight stages.
// The pipeline moves as one: while a result waits under i_edge_stall, every
// stage holds and o_pix_stall is raised.
// Writing image_width (index 0) or image_height (index 1) restarts the frame;
// write only while the block is empty. Reset restarts the frame at 1024x1024.
// The line ram needs no clearing pass: rows 0 and 1 of every frame fill each
// column before any window reads it.
// ----------------------------------------------------------------------------
module sobel_edge_magnitude #(
    parameter int MAX_WIDTH  = sem_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = sem_pkg::DEF_MAX_HEIGHT
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_pix_valid,
    output logic                           o_pix_stall,
    input  logic [sem_pkg::PIX_W-1:0]      i_pixel,
    output logic                           o_edge_valid,
    input  logic                           i_edge_stall,
    output logic [sem_pkg::ROOT_W-1:0]     o_edge_value,
    output logic [sem_pkg::POS_W-1:0]      o_centre_row,
    output logic [sem_pkg::POS_W-1:0]      o_centre_col,
    output logic                           o_frame_last,
    input  logic                           i_cfg_we,
    input  logic [sem_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [sem_pkg::CFG_W-1:0]      i_cfg_data
);

    import sem_pkg::*;

    logic  en;
    logic  grad_valid;
    t_grad grad;
    t_tag  tag;

    // whole pipeline advances unless a finished beat is held
    assign en          = !(o_edge_valid && i_edge_stall);
    assign o_pix_stall = !en;

    sem_window #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_window (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (en),
        .i_pix_valid (i_pix_valid),
        .i_pixel     (i_pixel),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_valid     (grad_valid),
        .o_grad      (grad)
    );

    sem_mag u_mag (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (en),
        .i_valid      (grad_valid),
        .i_grad       (grad),
        .o_valid      (o_edge_valid),
        .o_edge_value (o_edge_value),
        .o_tag        (tag)
    );

    assign o_centre_row = tag.row;
    assign o_centre_col = tag.col;
    assign o_frame_last = tag.last;

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: sobel edge magnitude testbench
// streams grey pixels through the block under a mix of frame sizes, including
// the clamped and largest ones; checks every edge beat field by field against
// typed beats or a line-store predictor kept in step with each accepted pixel
// ----------------------------------------------------------------------------
module tb_top;
    import sem_pkg::*;

    localparam int RANDOM_PIXELS = 820;
    localparam int DRAIN_CYCLES  = 16;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int BURST_WIDTH   = 64;
    localparam int BURST_ROWS    = 5;

    typedef struct packed {
        logic [ROOT_W-1:0] mag;
        logic [POS_W-1:0]  row;
        logic [POS_W-1:0]  col;
        logic              last;
    } t_edge_beat;

    typedef enum logic [1:0] {ROW_WRITE, ROW_TYPED, ROW_PREDICTED} t_row_kind;

    typedef struct {
        t_row_kind             kind;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_W-1:0]      data;
        logic [PIX_W-1:0]      pixel;
        bit                    has_beat;
        t_edge_beat            beat;
    } t_stim_row;

    localparam t_edge_beat NO_BEAT    = '0;
    localparam t_edge_beat SAT_CENTRE = '{MAG_MAX, 10'd1, 10'd1, 1'b1};

    logic                  i_clk        = 1'b0;
    logic                  i_rst_n      = 1'b0;
    logic                  i_pix_valid  = 1'b0;
    logic                  o_pix_stall;
    logic [PIX_W-1:0]      i_pixel      = '0;
    logic                  o_edge_valid;
    logic                  i_edge_stall = 1'b0;
    logic [ROOT_W-1:0]     o_edge_value;
    logic [POS_W-1:0]      o_centre_row;
    logic [POS_W-1:0]      o_centre_col;
    logic                  o_frame_last;
    logic                  i_cfg_we     = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index  = '0;
    logic [CFG_W-1:0]      i_cfg_data   = '0;

    sobel_edge_magnitude uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_pix_valid  (i_pix_valid),
        .o_pix_stall  (o_pix_stall),
        .i_pixel      (i_pixel),
        .o_edge_valid (o_edge_valid),
        .i_edge_stall (i_edge_stall),
        .o_edge_value (o_edge_value),
        .o_centre_row (o_centre_row),
        .o_centre_col (o_centre_col),
        .o_frame_last (o_frame_last),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // predictor state
    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] height_reg;
    logic [PIX_W-1:0] upper_line [DEF_MAX_WIDTH];
    logic [PIX_W-1:0] lower_line [DEF_MAX_WIDTH];
    logic [PIX_W-1:0] win_px [6];
    int               row_pos;
    int               col_pos;

    t_edge_beat pending_edges [$];
    t_edge_beat head;
    int         mismatch_count = 0;
    int         beats_checked  = 0;
    int         pixels_sent    = 0;
    int         random_pixels  = 0;
    int         setting_count  = 0;
    int         cycle_count    = 0;
    bit         src_idle_en    = 1'b1;
    bit         sink_idle_en   = 1'b1;

    t_stim_row directed_rows [30] = '{
        '{ROW_TYPED,     CFG_IMAGE_WIDTH,  11'd0,    8'd200, 1'b0, NO_BEAT},
        '{ROW_WRITE,     CFG_IMAGE_WIDTH,  11'd0,    8'd0,   1'b0, NO_BEAT},
        '{ROW_WRITE,     CFG_IMAGE_HEIGHT, 11'd2,    8'd0,   1'b0, NO_BEAT},
        // dark left, bright right column
        '{ROW_TYPED,     CFG_IMAGE_WIDTH,  11'd0,    8'd0,   1'b0, NO_BEAT},
        '{ROW_TYPED,     CFG_IMAGE_WIDTH,  11'd0,    8'd0,   1'b0, NO_BEAT},
        '{ROW_TYPED,     CFG_IMAGE_WIDTH,  11'd0,    8'd255, 1'b0, NO_BEAT},
        '{ROW_TYPED,     CFG_IMAGE_WIDTH,  11'd0,    8'd0,   1'b0, NO_BEAT},
        '{ROW_TYPED,     CFG_IMAGE_WIDTH,  11'd0,    8'd0,   1'b0, NO_BEAT},
        '{ROW_TYPED,     CFG_IMAGE_WIDTH,  11'd0,    8'd255, 1'b0, NO_BEAT},
        '{ROW_TYPED,     CFG_IMAGE_WIDTH,  11'd0,    8'd0,   1'b0, NO_BEAT},
        '{ROW_TYPED,     CFG_IMAGE_WIDTH,  11'd0,    8'd0,   1'b0, NO_BEAT},
        '{ROW_TYPED,     CFG_IMAGE_WIDTH,  11'd0,    8'd255, 1'b1, SAT_CENTRE},
        // bright top row, negative vertical gradient
        '{ROW_TYPED,     CFG_IMAGE_WIDTH,  11'd0,    8'd255, 1'b0, NO_BEAT},
        '{ROW_TYPED,     CFG_IMAGE_WIDTH,  11'd0,    8'd255, 1'b0, NO_BEAT},
        '{ROW_TYPED,     CFG_IMAGE_WIDTH,  11'd0,    8'd255, 1'b0, NO_BEAT},
        '{ROW_TYPED,     CFG_IMAGE_WIDTH,  11'd0,    8'd0,   1'b0, NO_BEAT},
        '{ROW_TYPED,     CFG_IMAGE_WIDTH,  11'd0,    8'd0,   1'b0, NO_BEAT},
        '{ROW_TYPED,     CFG_IMAGE_WIDTH,  11'd0,    8'd0,   1'b0, NO_BEAT},
        '{ROW_TYPED,     CFG_IMAGE_WIDTH,  11'd0,    8'd0,   1'b0, NO_BEAT},
        '{ROW_TYPED,     CFG_IMAGE_WIDTH,  11'd0,    8'd0,   1'b0, NO_BEAT},
        '{ROW_TYPED,     CFG_IMAGE_WIDTH,  11'd0,    8'd0,   1'b1, SAT_CENTRE},
        // mixed texture
        '{ROW_PREDICTED, CFG_IMAGE_WIDTH,  11'd0,    8'd12,  1'b0, NO_BEAT},
        '{ROW_PREDICTED, CFG_IMAGE_WIDTH,  11'd0,    8'd200, 1'b0, NO_BEAT},
        '{ROW_PREDICTED, CFG_IMAGE_WIDTH,  11'd0,    8'd37,  1'b0, NO_BEAT},
        '{ROW_PREDICTED, CFG_IMAGE_WIDTH,  11'd0,    8'd90,  1'b0, NO_BEAT},
        '{ROW_PREDICTED, CFG_IMAGE_WIDTH,  11'd0,    8'd91,  1'b0, NO_BEAT},
        '{ROW_PREDICTED, CFG_IMAGE_WIDTH,  11'd0,    8'd250, 1'b0, NO_BEAT},
        '{ROW_PREDICTED, CFG_IMAGE_WIDTH,  11'd0,    8'd3,   1'b0, NO_BEAT},
        '{ROW_PREDICTED, CFG_IMAGE_WIDTH,  11'd0,    8'd140, 1'b0, NO_BEAT},
        '{ROW_PREDICTED, CFG_IMAGE_WIDTH,  11'd0,    8'd66,  1'b0, NO_BEAT}
    };

    function automatic int eff_size(input logic [CFG_W-1:0] v);
        if (v < MIN_DIM) return MIN_DIM;
        if (v > DEF_MAX_WIDTH) return DEF_MAX_WIDTH;
        return int'(v);
    endfunction

    function automatic logic [CFG_W-1:0] pick_size();
        int roll;
        roll = $urandom_range(99);
        if (roll < 8) return CFG_W'($urandom_range(2));
        if (roll < 12) return CFG_W'($urandom_range(2047, 1025));
        return CFG_W'($urandom_range(12, 3));
    endfunction

    function automatic logic [PIX_W-1:0] rand_pixel(input bit extremes);
        if (extremes) return $urandom_range(1) ? 8'd255 : 8'd0;
        return PIX_W'($urandom_range(255));
    endfunction

    task automatic compute_edge(input logic [PIX_W-1:0] px, output bit produced,
                                output t_edge_beat beat);
        int w, h, r, c, top, mid, p, gx, gy, sq, root;
        w = eff_size(width_reg);
        h = eff_size(height_reg);
        r = row_pos;
        c = col_pos;
        if (c >= w) c = w - 1;
        if (r >= h) r = h - 1;
        top = int'(upper_line[c]);
        mid = int'(lower_line[c]);
        p = int'(px);
        produced = 1'b0;
        beat = NO_BEAT;
        if (r >= 2 && c >= 2) begin
            gx = (top + 2 * mid + p) - (int'(win_px[0]) + 2 * int'(win_px[1]) + int'(win_px[2]));
            gy = (int'(win_px[2]) + 2 * int'(win_px[5]) + p) - (int'(win_px[0])
                 + 2 * int'(win_px[3]) + top);
            sq = gx * gx + gy * gy;
            root = 0;
            while (root < 255 && (root + 1) * (root + 1) <= sq) root++;
            beat.mag  = root[ROOT_W-1:0];
            beat.row  = POS_W'(r - 1);
            beat.col  = POS_W'(c - 1);
            beat.last = (r == h - 1) && (c == w - 1);
            produced = 1'b1;
        end
        upper_line[c] = mid[PIX_W-1:0];
        lower_line[c] = px;
        win_px[0] = win_px[3];
        win_px[1] = win_px[4];
        win_px[2] = win_px[5];
        win_px[3] = top[PIX_W-1:0];
        win_px[4] = mid[PIX_W-1:0];
        win_px[5] = px;
        if (c + 1 >= w) begin
            col_pos = 0;
            row_pos = (r + 1 >= h) ? 0 : r + 1;
        end else begin
            col_pos = c + 1;
            row_pos = r;
        end
    endtask

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_pixel(input logic [PIX_W-1:0] px, input bit typed,
                              input bit typed_has, input t_edge_beat typed_beat);
        bit produced;
        t_edge_beat beat;
        while (src_idle_en && $urandom_range(99) < 12) begin
            i_pix_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_pix_valid <= 1'b1;
        i_pixel <= px;
        @(posedge i_clk);
        while (o_pix_stall) @(posedge i_clk);
        compute_edge(px, produced, beat);
        if (typed) begin
            if (typed_has) pending_edges.push_back(typed_beat);
        end else if (produced) begin
            pending_edges.push_back(beat);
        end
        pixels_sent++;
        @(negedge i_clk);
    endtask

    task automatic settle();
        i_pix_valid <= 1'b0;
        while (pending_edges.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_IMAGE_WIDTH) width_reg = val;
        else height_reg = val;
        row_pos = 0;
        col_pos = 0;
        @(negedge i_clk);
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t: edge beat %s expected %0d actual %0d", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_edge_valid && !i_edge_stall) begin
            if (pending_edges.size() == 0) begin
                $display("%0t: edge beat expected none actual mag %0d row %0d col %0d last %0d",
                         $time, o_edge_value, o_centre_row, o_centre_col, o_frame_last);
                mismatch_count++;
            end else begin
                head = pending_edges.pop_front();
                check_field("mag", int'(head.mag), int'(o_edge_value));
                check_field("row", int'(head.row), int'(o_centre_row));
                check_field("col", int'(head.col), int'(o_centre_col));
                check_field("last", int'(head.last), int'(o_frame_last));
                beats_checked++;
            end
        end
    end

    always @(negedge i_clk) begin
        i_edge_stall <= sink_idle_en && ($urandom_range(99) < 12);
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d beats outstanding", $time, pending_edges.size());
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        int n, frame, pick;
        bit one_reg, extremes;
        width_reg = CFG_W'(DIM_RESET);
        height_reg = CFG_W'(DIM_RESET);
        foreach (upper_line[k]) begin
            upper_line[k] = '0;
            lower_line[k] = '0;
        end
        foreach (win_px[k]) win_px[k] = '0;
        row_pos = 0;
        col_pos = 0;

        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (directed_rows[k]) begin
            case (directed_rows[k].kind)
                ROW_WRITE: begin
                    settle();
                    write_reg(directed_rows[k].idx, directed_rows[k].data);
                end
                ROW_TYPED: begin
                    send_pixel(directed_rows[k].pixel, 1'b1, directed_rows[k].has_beat,
                               directed_rows[k].beat);
                end
                default: begin
                    send_pixel(directed_rows[k].pixel, 1'b0, 1'b0, NO_BEAT);
                end
            endcase
        end

        // full frame back to back with no idling on either side
        settle();
        src_idle_en = 1'b0;
        sink_idle_en = 1'b0;
        write_reg(CFG_IMAGE_WIDTH, CFG_W'(BURST_WIDTH));
        write_reg(CFG_IMAGE_HEIGHT, CFG_W'(BURST_ROWS));
        setting_count++;
        repeat (BURST_WIDTH * BURST_ROWS) send_pixel(rand_pixel(1'b0), 1'b0, 1'b0, NO_BEAT);
        settle();
        src_idle_en = 1'b1;
        sink_idle_en = 1'b1;

        // tallest frame clamped from the top code, left unfinished
        write_reg(CFG_IMAGE_WIDTH, 11'd1);
        write_reg(CFG_IMAGE_HEIGHT, 11'd2047);
        setting_count++;
        repeat (90) send_pixel(rand_pixel(1'b0), 1'b0, 1'b0, NO_BEAT);

        while (random_pixels < RANDOM_PIXELS) begin
            settle();
            one_reg = ($urandom_range(4) == 0);
            pick = $urandom_range(1);
            if (!one_reg || pick == 0) write_reg(CFG_IMAGE_WIDTH, pick_size());
            if (!one_reg || pick == 1) write_reg(CFG_IMAGE_HEIGHT, pick_size());
            setting_count++;
            frame = eff_size(width_reg) * eff_size(height_reg);
            if (frame <= 150) begin
                n = frame * $urandom_range(3, 1);
                // broken tail: a partial frame cut off by the next write
                if ($urandom_range(3) == 0) n += $urandom_range(frame - 1, 1);
            end else begin
                n = $urandom_range(150, 20);
            end
            extremes = ($urandom_range(4) == 0);
            repeat (n) begin
                send_pixel(rand_pixel(extremes), 1'b0, 1'b0, NO_BEAT);
                random_pixels++;
            end
        end

        settle();
        $display("streamed %0d pixels under %0d size settings, %0d edge beats compared",
                 pixels_sent, setting_count, beats_checked);
        if (mismatch_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("%0d mismatches", mismatch_count);
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
